### rtl/lattice_cyclic_dominance_update_defines.svh
// Assertion macros for the lattice update block.
`ifndef LATTICE_CYCLIC_DOMINANCE_UPDATE_DEFINES_SVH
`define LATTICE_CYCLIC_DOMINANCE_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/lcd_pkg.sv
`default_nettype none

package lcd_pkg;

  localparam int unsigned COORD_W     = 7;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [31:0] ACTION_TABLE_RESET = 32'h3E4F_519C;
  localparam logic [15:0] THRESHOLD_RESET    = 16'h0000;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTION_TABLE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWAP_THRESHOLD = 1'b1;

  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] DIR_ROW_INC = 2'd0;
  localparam logic [1:0] DIR_COL_INC = 2'd1;
  localparam logic [1:0] DIR_ROW_DEC = 2'd2;
  localparam logic [1:0] DIR_COL_DEC = 2'd3;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SPREAD = 2'd1;
  localparam logic [1:0] ACT_SWAP   = 2'd2;
  localparam logic [1:0] ACT_TAKE   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [1:0]         direction;
    logic signed [15:0] random_value;
    logic [1:0]         cell_value;
  } lcd_req_t;

  typedef struct packed {
    logic [1:0] action_taken;
    logic [1:0] site_species;
    logic [1:0] neighbour_species;
    logic       swapped;
  } lcd_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP
  } lcd_state_e;

endpackage

`default_nettype wire

### rtl/lcd_stream_if.sv
`default_nettype none

interface lcd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/lattice_cyclic_dominance_update.sv
// Lattice cyclic-dominance update block.
// req_i carries one transaction per item: update step, cell write or cell
// read, with site, direction, random draw and write value. rsp_o returns
// exactly one transaction per item, in order. cfg_we_i/cfg_index_i/cfg_data_i
// write the action table (index 0) and the signed swap threshold (index 1).
// The grid sits in one memory with two read ports, one write port and a
// registered read. An item is taken in the idle state (both cells read)
// and finished in the execute state (action lookup, first write, result
// loaded); a swap that passes the threshold goes on to a swap state,
// whose second write needs the single write port once more. A new item
// is taken only in the idle state.
// The output register lets a new item be taken while a result waits; when
// the receiver stalls with a result still waiting, the next item holds in
// its finish cycle until the output register frees.
// Reset sets the configuration registers to their defaults, clears the output valid and sets the control state to idle.
// Grid cells are not cleared: each cell must be written before it is read.
`default_nettype none

`include "lattice_cyclic_dominance_update_defines.svh"

module lattice_cyclic_dominance_update
  import lcd_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 128
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  lcd_stream_if.sink            req_i,
  lcd_stream_if.source          rsp_o
);

  localparam int unsigned IDX_W    = $clog2(GRID_SIDE);
  localparam int unsigned DEPTH    = GRID_SIDE * GRID_SIDE;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SPAN     = 2 ** COORD_W;
  localparam logic [IDX_W-1:0]  SIDE_MAX = IDX_W'(GRID_SIDE - 1);
  localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(GRID_SIDE);

  logic [31:0]        action_table_q;
  logic signed [15:0] threshold_q;

  lcd_state_e state_q, state_d;

  logic [1:0]         mode_q;
  logic [1:0]         wval_q;
  logic signed [15:0] rnd_q;
  logic [ADDR_W-1:0]  site_addr_q, nb_addr_q;
  logic [ADDR_W-1:0]  site_addr_d, nb_addr_d;
  logic [1:0]         rd_site_q, rd_nb_q;

  lcd_rsp_t rsp_q, rsp_d;
  logic     rsp_valid_q;
  logic     rsp_load;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [1:0]        mem_wdata;
  logic [1:0]        grid_mem [DEPTH];

  logic accept;

  logic [IDX_W-1:0] coord_mod [SPAN];
  logic [IDX_W-1:0] r1, c1, r2, c2;

  for (genvar i = 0; i < SPAN; i++) begin : g_mod
    assign coord_mod[i] = IDX_W'(i % GRID_SIDE);
  end

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    r1 = coord_mod[req_i.data.row];
    c1 = coord_mod[req_i.data.col];
    r2 = r1;
    c2 = c1;
    case (req_i.data.direction)
      DIR_ROW_INC: r2 = (r1 == SIDE_MAX) ? '0 : r1 + 1'b1;
      DIR_COL_INC: c2 = (c1 == SIDE_MAX) ? '0 : c1 + 1'b1;
      DIR_ROW_DEC: r2 = (r1 == '0) ? SIDE_MAX : r1 - 1'b1;
      DIR_COL_DEC: c2 = (c1 == '0) ? SIDE_MAX : c1 - 1'b1;
      default:     r2 = r1;
    endcase
    site_addr_d = ADDR_W'(ADDR_W'(r1) * SIDE_A) + ADDR_W'(c1);
    nb_addr_d   = ADDR_W'(ADDR_W'(r2) * SIDE_A) + ADDR_W'(c2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_table_q <= ACTION_TABLE_RESET;
      threshold_q    <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACTION_TABLE:   action_table_q <= cfg_data_i;
        REG_SWAP_THRESHOLD: threshold_q    <= cfg_data_i[15:0];
        default:            action_table_q <= action_table_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_site_q <= grid_mem[site_addr_d];
      rd_nb_q   <= grid_mem[nb_addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q      <= req_i.data.mode;
      wval_q      <= req_i.data.cell_value;
      rnd_q       <= req_i.data.random_value;
      site_addr_q <= site_addr_d;
      nb_addr_q   <= nb_addr_d;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  logic [1:0] act;
  logic       swap_ok;
  logic       out_free;

  assign act      = action_table_q[{rd_site_q, rd_nb_q, 1'b0} +: 2];
  assign swap_ok  = (act == ACT_SWAP) && (rnd_q < threshold_q);
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = site_addr_q;
    mem_wdata = rd_nb_q;
    rsp_load  = 1'b0;
    rsp_d     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_STEP: begin
            rsp_d.action_taken = act;
            rsp_d.swapped      = swap_ok;
            case (act)
              ACT_SPREAD: begin
                rsp_d.site_species      = rd_site_q;
                rsp_d.neighbour_species = rd_site_q;
                mem_we    = out_free;
                mem_waddr = nb_addr_q;
                mem_wdata = rd_site_q;
              end
              ACT_SWAP: begin
                rsp_d.site_species      = swap_ok ? rd_nb_q : rd_site_q;
                rsp_d.neighbour_species = swap_ok ? rd_site_q : rd_nb_q;
                mem_we = out_free && swap_ok;
              end
              ACT_TAKE: begin
                rsp_d.site_species      = rd_nb_q;
                rsp_d.neighbour_species = rd_nb_q;
                mem_we = out_free;
              end
              default: begin
                rsp_d.site_species      = rd_site_q;
                rsp_d.neighbour_species = rd_nb_q;
              end
            endcase
          end
          MODE_WRITE: begin
            rsp_d.site_species = wval_q;
            mem_we    = out_free;
            mem_wdata = wval_q;
          end
          default: begin
            rsp_d.site_species = rd_site_q;
          end
        endcase
        if (out_free) begin
          rsp_load = 1'b1;
          state_d  = (mode_q == MODE_STEP && swap_ok) ? ST_SWAP : ST_IDLE;
        end
      end
      ST_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = nb_addr_q;
        mem_wdata = rd_site_q;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  `LCD_ASSERT(a_accept_to_exec, clk_i, rst_ni, accept |=> state_q == ST_EXEC, "accepted transaction did not enter execution")
  `LCD_ASSERT(a_swap_has_result, clk_i, rst_ni, (state_q == ST_SWAP) |-> (rsp_valid_q && rsp_q.swapped), "second swap write without a swap result")
  `LCD_ASSERT(a_swap_distinct, clk_i, rst_ni, (state_q == ST_SWAP) |-> (nb_addr_q != site_addr_q), "swap writes the site twice")
  `LCD_ASSERT_ALWAYS(a_idle_no_write, clk_i, (state_q == ST_IDLE) |-> !mem_we, "grid written while idle")

endmodule

`default_nettype wire

### verif/lattice_cyclic_dominance_update_tb.sv
module lattice_cyclic_dominance_update_tb;
  import lcd_pkg::*;

  localparam int unsigned GRID_SIDE    = 128;
  localparam int unsigned GRID_CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned IDLE_PERCENT = 21;
  localparam logic [1:0]  MODE_READ_ALT = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  lcd_stream_if #(.T(lcd_req_t)) req_if ();
  lcd_stream_if #(.T(lcd_rsp_t)) rsp_if ();

  lattice_cyclic_dominance_update #(.GRID_SIDE(GRID_SIDE)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  logic [1:0]         species_grid [GRID_CELLS];
  bit                 cell_written [GRID_CELLS];
  int unsigned        written_list [$];
  logic [31:0]        action_map;
  logic signed [15:0] swap_limit;
  lcd_rsp_t           expected_rsps [$];

  int unsigned sent_items   = 0;
  int unsigned result_count = 0;
  int unsigned mismatches   = 0;
  int unsigned hold_cycles  = 0;
  bit          calm         = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned neighbour_of(int unsigned row, int unsigned col,
                                               logic [1:0] dir);
    int unsigned r2;
    int unsigned c2;
    r2 = row;
    c2 = col;
    case (dir)
      DIR_ROW_INC: r2 = (row == GRID_SIDE - 1) ? 0 : row + 1;
      DIR_COL_INC: c2 = (col == GRID_SIDE - 1) ? 0 : col + 1;
      DIR_ROW_DEC: r2 = (row == 0) ? GRID_SIDE - 1 : row - 1;
      DIR_COL_DEC: c2 = (col == 0) ? GRID_SIDE - 1 : col - 1;
    endcase
    return r2 * GRID_SIDE + c2;
  endfunction

  function automatic lcd_rsp_t evolve_grid(lcd_req_t item);
    lcd_rsp_t    rsp;
    int unsigned row;
    int unsigned col;
    int unsigned site;
    int unsigned nb;
    logic [1:0]  s1;
    logic [1:0]  s2;
    logic [3:0]  pair;
    rsp  = '0;
    row  = item.row % GRID_SIDE;
    col  = item.col % GRID_SIDE;
    site = row * GRID_SIDE + col;
    if (item.mode == MODE_STEP) begin
      nb   = neighbour_of(row, col, item.direction);
      s1   = species_grid[site];
      s2   = species_grid[nb];
      pair = {s1, s2};
      rsp.action_taken = action_map[2 * pair +: 2];
      case (rsp.action_taken)
        ACT_SPREAD: species_grid[nb] = s1;
        ACT_SWAP: begin
          if ($signed(item.random_value) < swap_limit) begin
            species_grid[site] = s2;
            species_grid[nb]   = s1;
            rsp.swapped        = 1'b1;
          end
        end
        ACT_TAKE: species_grid[site] = s2;
        default: ;
      endcase
      rsp.neighbour_species = species_grid[nb];
    end else if (item.mode == MODE_WRITE) begin
      species_grid[site] = item.cell_value;
      if (!cell_written[site]) begin
        cell_written[site] = 1'b1;
        written_list = {written_list, site};
      end
    end
    rsp.site_species = species_grid[site];
    return rsp;
  endfunction

  function automatic lcd_req_t make_req(logic [1:0] mode, int unsigned row, int unsigned col,
                                        logic [1:0] dir, logic [15:0] rnd, logic [1:0] val);
    lcd_req_t item;
    item.mode         = mode;
    item.row          = COORD_W'(row);
    item.col          = COORD_W'(col);
    item.direction    = dir;
    item.random_value = rnd;
    item.cell_value   = val;
    return item;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [1:0] got, logic [1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    lcd_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      result_count++;
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                  result_count));
      end else begin
        want = expected_rsps.pop_front();
        compare_field("action_taken", rsp_if.data.action_taken, want.action_taken);
        compare_field("site_species", rsp_if.data.site_species, want.site_species);
        compare_field("neighbour_species", rsp_if.data.neighbour_species,
                      want.neighbour_species);
        compare_field("swapped", rsp_if.data.swapped, want.swapped);
      end
    end
  end

  // hold ready low for the requested stretch, otherwise stall at random unless calm is set
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_req(lcd_req_t item);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsps = {expected_rsps, evolve_grid(item)};
    sent_items++;
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] tbl, logic [15:0] thr);
    wait_for_results();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ACTION_TABLE;
    cfg_data_i  <= tbl;
    @(posedge clk_i);
    cfg_index_i <= REG_SWAP_THRESHOLD;
    cfg_data_i  <= {{16{thr[15]}}, thr};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    action_map = tbl;
    swap_limit = thr;
  endtask

  task automatic write_cell(int unsigned row, int unsigned col, logic [1:0] val);
    send_req(make_req(MODE_WRITE, row, col, 2'($urandom_range(3)), 16'($urandom), val));
  endtask

  task automatic read_cell(int unsigned idx, logic [1:0] mode);
    send_req(make_req(mode, idx / GRID_SIDE, idx % GRID_SIDE, 2'($urandom_range(3)),
                      16'($urandom), 2'($urandom_range(3))));
  endtask

  // load a random species into a cell not yet written, before anything reads it
  task automatic seed_cell(int unsigned idx);
    if (!cell_written[idx]) begin
      write_cell(idx / GRID_SIDE, idx % GRID_SIDE, 2'($urandom_range(3)));
    end
  endtask

  task automatic step_site(int unsigned row, int unsigned col, logic [1:0] dir,
                           logic [15:0] rnd);
    seed_cell(row * GRID_SIDE + col);
    seed_cell(neighbour_of(row, col, dir));
    send_req(make_req(MODE_STEP, row, col, dir, rnd, 2'($urandom_range(3))));
  endtask

  task automatic random_item(int unsigned patch_row, int unsigned patch_col);
    int unsigned pick;
    int unsigned row;
    int unsigned col;
    int unsigned idx;
    pick = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      row = (patch_row + $urandom_range(5)) % GRID_SIDE;
      col = (patch_col + $urandom_range(5)) % GRID_SIDE;
    end else begin
      row = $urandom_range(GRID_SIDE - 1);
      col = $urandom_range(GRID_SIDE - 1);
    end
    if (pick < 70) begin
      step_site(row, col, 2'($urandom_range(3)), 16'($urandom));
    end else if (pick < 85) begin
      write_cell(row, col, 2'($urandom_range(3)));
    end else begin
      idx = written_list[$urandom_range(written_list.size() - 1)];
      read_cell(idx, ($urandom_range(1) == 0) ? MODE_READ : MODE_READ_ALT);
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned first;
    int unsigned patch_row;
    int unsigned patch_col;
    first     = sent_items;
    patch_row = ($urandom_range(1) == 0) ? GRID_SIDE - 3 : $urandom_range(GRID_SIDE - 1);
    patch_col = ($urandom_range(1) == 0) ? GRID_SIDE - 3 : $urandom_range(GRID_SIDE - 1);
    while (sent_items - first < count) random_item(patch_row, patch_col);
  endtask

  task automatic test_wraparound();
    write_cell(0, 0, 2'd1);
    write_cell(GRID_SIDE - 1, 0, 2'd2);
    write_cell(0, GRID_SIDE - 1, 2'd3);
    write_cell(GRID_SIDE - 1, GRID_SIDE - 1, 2'd0);
    step_site(0, 0, DIR_ROW_DEC, 16'h8000);
    step_site(0, 0, DIR_COL_DEC, 16'h7FFF);
    step_site(GRID_SIDE - 1, GRID_SIDE - 1, DIR_ROW_INC, 16'h0000);
    step_site(GRID_SIDE - 1, GRID_SIDE - 1, DIR_COL_INC, 16'hFFFF);
    read_cell(GRID_CELLS - 1, MODE_READ);
    read_cell(0, MODE_READ_ALT);
  endtask

  task automatic test_each_action();
    logic [1:0] acts [4] = '{ACT_NONE, ACT_SPREAD, ACT_SWAP, ACT_TAKE};
    foreach (acts[i]) begin
      configure({16{acts[i]}}, 16'h7FFF);
      step_site(0, 0, DIR_ROW_INC, 16'h8000);
    end
  endtask

  task automatic test_swap_threshold();
    configure({16{ACT_SWAP}}, 16'h8000);
    step_site(1, 1, DIR_COL_INC, 16'h8000);
    configure({16{ACT_SWAP}}, 16'h0800);
    step_site(1, 1, DIR_COL_INC, 16'h0800);
    step_site(1, 1, DIR_COL_INC, 16'h07FF);
    configure({16{ACT_SWAP}}, 16'h7FFF);
    step_site(1, 1, DIR_COL_INC, 16'h7FFF);
    step_site(1, 1, DIR_ROW_DEC, 16'h7FFE);
  endtask

  task automatic test_random_configs();
    logic [31:0] tbl;
    logic [15:0] thr;
    for (int phase = 0; phase < 5; phase++) begin
      tbl = $urandom;
      thr = 16'($urandom);
      case (phase)
        0: begin
          tbl = ACTION_TABLE_RESET;
          thr = THRESHOLD_RESET;
        end
        1: thr = 16'h8000;
        2: thr = 16'h7FFF;
        default: ;
      endcase
      calm = (phase == 3);
      configure(tbl, thr);
      run_random(75);
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    configure($urandom, 16'($urandom));
    calm        = 1'b1;
    hold_cycles = 200;
    run_random(40);
    calm = 1'b0;
    wait_for_results();
    run_random(40);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_ACTION_TABLE;
    cfg_data_i   <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    action_map = ACTION_TABLE_RESET;
    swap_limit = THRESHOLD_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wraparound();
    test_each_action();
    test_swap_threshold();
    test_random_configs();
    test_backpressure();

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lcd_pkg.sv
rtl/lcd_stream_if.sv
rtl/lattice_cyclic_dominance_update.sv
verif/lattice_cyclic_dominance_update_tb.sv
